[rtl/rcwt_pkg.sv]
// package for the roi crop window tracker
// shared types, field widths, register indexes and controller codes; no dependencies
package rcwt_pkg;

  localparam int COORD_FRAC = 4;
  localparam int XW = 17;
  localparam int SW = 13;
  localparam int PW = 14;
  localparam int ZW = 16;
  localparam logic [SW-1:0] SIZE_MAX = 13'd4096;
  localparam logic [ZW-1:0] ZOOM_ONE = 16'd256;

  localparam int DIV_DW = 36;
  localparam int DIV_VW = 30;
  localparam int MUL_AW = 26;
  localparam int MUL_BW = 16;
  localparam int MUL_PW = 42;

  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_OUT_WIDTH    = 3'd2;
  localparam logic [2:0] REG_OUT_HEIGHT   = 3'd3;
  localparam logic [2:0] REG_ZOOM         = 3'd4;
  localparam logic [2:0] REG_WINDOW       = 3'd5;
  localparam logic [2:0] REG_REPLICATE    = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE, S_CENTER, S_CHK, S_RD_F, S_SUB_F, S_WRITE, S_TRIM,
    S_RD_T, S_SUB_T, S_DIV_GO, S_DIV_WAIT, S_MUL, S_CMP, S_FIN
  } state_t;

  typedef enum logic [1:0] {D_MEAN_X, D_MEAN_Y, D_SIZE1, D_SIZE2} div_sel_t;
  typedef enum logic [1:0] {M_A, M_B, M_BZ, M_Z} mul_sel_t;

  typedef struct packed {
    logic [SW-1:0] frame_width;
    logic [SW-1:0] frame_height;
    logic [SW-1:0] out_width;
    logic [SW-1:0] out_height;
    logic [ZW-1:0] zoom_q8;
    logic [5:0]    smoothing_window;
    logic          replicate_border;
  } cfg_t;

  typedef struct packed {
    logic     capture;
    logic     center;
    logic     rd;
    logic     sub;
    logic     write;
    logic     div_start;
    logic     div_store;
    div_sel_t div_sel;
    logic     mul_go;
    mul_sel_t mul_sel;
    logic     cmp;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic over;
    logic div_done;
  } stat_t;

endpackage

[rtl/rcwt_div.sv]
// radix-2 restoring divider, one quotient bit per cycle
// stand-alone; used by the datapath
module rcwt_div #(
  parameter int DW = 36,
  parameter int VW = 30
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output logic          done
);

  localparam int CTW = $clog2(DW + 1);

  logic [DW-1:0]  dvd;
  logic [VW-1:0]  rem;
  logic [VW-1:0]  dvs;
  logic [CTW-1:0] cnt;
  logic           busy;
  logic [VW:0]    rem_sh;
  logic           ge;

  assign rem_sh   = {rem, dvd[DW-1]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CTW'(DW);
    end else if (busy) begin
      cnt <= cnt - CTW'(1);
      if (cnt == CTW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? VW'(rem_sh - {1'b0, dvs}) : rem_sh[VW-1:0];
      dvd <= {dvd[DW-2:0], ge};
    end
  end

endmodule

[rtl/rcwt_datapath.sv]
// datapath: center history ring, running sums, multiplier, divider, crop placement
// uses rcwt_pkg and rcwt_div
module rcwt_datapath #(
  parameter int MAX_WINDOW = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  rcwt_pkg::cfg_t              cfg,
  input  rcwt_pkg::cmd_t              cmd,
  output rcwt_pkg::stat_t             stat,
  input  logic                        clip_start,
  input  logic                        roi_valid,
  input  logic signed [16:0]          roi_x,
  input  logic signed [16:0]          roi_y,
  output logic signed [16:0]          smooth_x,
  output logic signed [16:0]          smooth_y,
  output logic signed [13:0]          crop_left,
  output logic signed [13:0]          crop_top,
  output logic [12:0]                 crop_width,
  output logic [12:0]                 crop_height,
  output logic [13:0]                 pad_left,
  output logic [13:0]                 pad_top,
  output logic [13:0]                 pad_right,
  output logic [13:0]                 pad_bottom
);

  localparam int XW   = rcwt_pkg::XW;
  localparam int SW   = rcwt_pkg::SW;
  localparam int PW   = rcwt_pkg::PW;
  localparam int ZW   = rcwt_pkg::ZW;
  localparam int F    = rcwt_pkg::COORD_FRAC;
  localparam int DW   = rcwt_pkg::DIV_DW;
  localparam int VW   = rcwt_pkg::DIV_VW;
  localparam int AW   = rcwt_pkg::MUL_AW;
  localparam int BW   = rcwt_pkg::MUL_BW;
  localparam int MPW  = rcwt_pkg::MUL_PW;
  localparam int IDXW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNTW = $clog2(MAX_WINDOW + 1);
  localparam int SUMW = XW + CNTW;
  localparam int ZPW  = ZW + SW;

  // history ring
  logic [2*XW-1:0] hist_mem [MAX_WINDOW];

  logic                   in_clip, in_vld;
  logic signed [XW-1:0]   in_x, in_y;
  logic signed [XW-1:0]   cx, cy;
  logic [CNTW-1:0]        count;
  logic [IDXW-1:0]        head;
  logic signed [SUMW-1:0] sum_x, sum_y;
  logic signed [XW-1:0]   last_x, last_y;
  logic                   have_last;
  logic signed [XW-1:0]   rd_x, rd_y;
  logic signed [XW-1:0]   sx, sy;
  logic [AW-1:0]          prod_a, prod_b;
  logic [MPW-1:0]         prod_bz;
  logic [ZPW-1:0]         prod_z;
  logic                   height_fit;
  logic [SW-1:0]          cw, ch;

  // effective configuration
  logic [SW-1:0] fw, fh, ow_s, oh_s, ow_e, oh_e, o1, f1;
  logic [ZW-1:0] z_e;
  logic [CNTW+5:0] win_ext;
  logic [CNTW-1:0] win_eff;

  function automatic logic [SW-1:0] sat_frame(input logic [SW-1:0] v);
    if (v == '0) return SW'(1);
    if (v > rcwt_pkg::SIZE_MAX) return rcwt_pkg::SIZE_MAX;
    return v;
  endfunction

  function automatic logic [SW-1:0] clamp_q(input logic [DW-1:0] q, input logic [SW-1:0] lim);
    if (q == '0) return SW'(1);
    if (q > DW'(lim)) return lim;
    return q[SW-1:0];
  endfunction

  function automatic logic signed [PW-1:0] round_pix(input logic signed [19:0] v);
    logic [19:0] mag;
    logic [19:0] r;
    mag = v[19] ? 20'(-v) : 20'(v);
    r = (mag + (20'(1) << F)) >> (F + 1);
    return v[19] ? -PW'(r) : PW'(r);
  endfunction

  always_comb begin
    fw   = sat_frame(cfg.frame_width);
    fh   = sat_frame(cfg.frame_height);
    ow_s = (cfg.out_width > rcwt_pkg::SIZE_MAX) ? rcwt_pkg::SIZE_MAX : cfg.out_width;
    oh_s = (cfg.out_height > rcwt_pkg::SIZE_MAX) ? rcwt_pkg::SIZE_MAX : cfg.out_height;
    // either output size zero means frame size
    if (ow_s == '0 || oh_s == '0) begin
      ow_e = fw;
      oh_e = fh;
    end else begin
      ow_e = ow_s;
      oh_e = oh_s;
    end
    z_e = (cfg.zoom_q8 < rcwt_pkg::ZOOM_ONE) ? rcwt_pkg::ZOOM_ONE : cfg.zoom_q8;
    win_ext = (CNTW+6)'(cfg.smoothing_window);
    if (win_ext == '0) win_eff = CNTW'(1);
    else if (win_ext > (CNTW+6)'(MAX_WINDOW)) win_eff = CNTW'(MAX_WINDOW);
    else win_eff = win_ext[CNTW-1:0];
    o1 = height_fit ? oh_e : ow_e;
    f1 = height_fit ? fh : fw;
  end

  assign stat.full = (count == CNTW'(MAX_WINDOW));
  assign stat.over = (count > win_eff);

  // oldest entry of the ring
  logic [CNTW:0]   old_t;
  logic [IDXW-1:0] old_idx;
  always_comb begin
    old_t = (CNTW+1)'(head) + (CNTW+1)'(MAX_WINDOW) - (CNTW+1)'(count);
    if (old_t >= (CNTW+1)'(MAX_WINDOW)) old_t = old_t - (CNTW+1)'(MAX_WINDOW);
    old_idx = old_t[IDXW-1:0];
  end

  // frame middle
  logic [XW:0] mid_x, mid_y;
  assign mid_x = (((XW+1)'(fw) << F) + (XW+1)'(1)) >> 1;
  assign mid_y = (((XW+1)'(fh) << F) + (XW+1)'(1)) >> 1;

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      {rd_x, rd_y} <= hist_mem[old_idx];
    end
    if (cmd.write) begin
      hist_mem[head] <= {cx, cy};
    end
  end

  // shared multiplier
  logic [AW-1:0]  mul_a;
  logic [BW-1:0]  mul_b;
  logic [MPW-1:0] mul_p;
  always_comb begin
    unique case (cmd.mul_sel)
      rcwt_pkg::M_A:  begin mul_a = AW'(fw);  mul_b = BW'(oh_e); end
      rcwt_pkg::M_B:  begin mul_a = AW'(fh);  mul_b = BW'(ow_e); end
      rcwt_pkg::M_BZ: begin mul_a = prod_b;   mul_b = z_e;       end
      default:        begin mul_a = AW'(o1);  mul_b = z_e;       end
    endcase
  end
  assign mul_p = MPW'(mul_a) * MPW'(mul_b);

  // divider operands
  logic [SUMW-1:0] mag_x, mag_y;
  logic [AW-1:0]   pn;
  logic [DW-1:0]   div_dvd, div_q;
  logic [VW-1:0]   div_dvs;
  logic            div_done;
  assign mag_x = sum_x[SUMW-1] ? SUMW'(-sum_x) : SUMW'(sum_x);
  assign mag_y = sum_y[SUMW-1] ? SUMW'(-sum_y) : SUMW'(sum_y);
  assign pn    = height_fit ? prod_b : prod_a;

  always_comb begin
    unique case (cmd.div_sel)
      rcwt_pkg::D_MEAN_X: begin
        div_dvd = DW'({mag_x, 1'b0}) + DW'(count);
        div_dvs = VW'({count, 1'b0});
      end
      rcwt_pkg::D_MEAN_Y: begin
        div_dvd = DW'({mag_y, 1'b0}) + DW'(count);
        div_dvs = VW'({count, 1'b0});
      end
      rcwt_pkg::D_SIZE1: begin
        div_dvd = DW'({f1, 9'b0}) + DW'(z_e);
        div_dvs = VW'({z_e, 1'b0});
      end
      default: begin
        div_dvd = DW'({pn, 9'b0}) + DW'(prod_z);
        div_dvs = VW'({prod_z, 1'b0});
      end
    endcase
  end

  rcwt_div #(.DW(DW), .VW(VW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .done     (div_done)
  );
  assign stat.div_done = div_done;

  logic signed [XW-1:0] q_sx, q_sy;
  assign q_sx = sum_x[SUMW-1] ? -XW'(div_q) : XW'(div_q);
  assign q_sy = sum_y[SUMW-1] ? -XW'(div_q) : XW'(div_q);

  // control state of the history
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      head      <= '0;
      sum_x     <= '0;
      sum_y     <= '0;
      last_x    <= '0;
      last_y    <= '0;
      have_last <= 1'b0;
    end else begin
      if (cmd.center && in_clip) begin
        count     <= '0;
        head      <= '0;
        sum_x     <= '0;
        sum_y     <= '0;
        have_last <= 1'b0;
      end
      if (cmd.sub) begin
        count <= count - CNTW'(1);
        sum_x <= sum_x - SUMW'(rd_x);
        sum_y <= sum_y - SUMW'(rd_y);
      end
      if (cmd.write) begin
        count <= count + CNTW'(1);
        head  <= (head == IDXW'(MAX_WINDOW - 1)) ? '0 : head + IDXW'(1);
        sum_x <= sum_x + SUMW'(cx);
        sum_y <= sum_y + SUMW'(cy);
      end
      if (cmd.div_store && cmd.div_sel == rcwt_pkg::D_MEAN_X) begin
        last_x <= q_sx;
      end
      if (cmd.div_store && cmd.div_sel == rcwt_pkg::D_MEAN_Y) begin
        last_y    <= q_sy;
        have_last <= 1'b1;
      end
    end
  end

  // request payload and working values
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_clip <= clip_start;
      in_vld  <= roi_valid;
      in_x    <= roi_x;
      in_y    <= roi_y;
    end
    if (cmd.center) begin
      if (in_vld) begin
        cx <= in_x;
        cy <= in_y;
      end else if (have_last && !in_clip) begin
        cx <= last_x;
        cy <= last_y;
      end else begin
        cx <= XW'(mid_x);
        cy <= XW'(mid_y);
      end
    end
    if (cmd.mul_go) begin
      unique case (cmd.mul_sel)
        rcwt_pkg::M_A:  prod_a  <= mul_p[AW-1:0];
        rcwt_pkg::M_B:  prod_b  <= mul_p[AW-1:0];
        rcwt_pkg::M_BZ: prod_bz <= mul_p;
        default:        prod_z  <= mul_p[ZPW-1:0];
      endcase
    end
    if (cmd.cmp) begin
      height_fit <= (MPW'({prod_a, 8'b0}) > prod_bz);
    end
    if (cmd.div_store) begin
      unique case (cmd.div_sel)
        rcwt_pkg::D_MEAN_X: sx <= q_sx;
        rcwt_pkg::D_MEAN_Y: sy <= q_sy;
        rcwt_pkg::D_SIZE1: begin
          if (height_fit) ch <= clamp_q(div_q, fh);
          else            cw <= clamp_q(div_q, fw);
        end
        default: begin
          if (height_fit) cw <= clamp_q(div_q, fw);
          else            ch <= clamp_q(div_q, fh);
        end
      endcase
    end
  end

  // crop placement
  logic signed [19:0]   vx, vy;
  logic signed [PW-1:0] left, top, left_c, top_c;
  logic signed [PW:0]   pr, pb;
  logic [SW-1:0]        mx, my;

  always_comb begin
    vx = (20'(sx) <<< 1) - $signed(20'(cw) << F);
    vy = (20'(sy) <<< 1) - $signed(20'(ch) << F);
    left = round_pix(vx);
    top  = round_pix(vy);
    pr = (PW+1)'(left) + $signed((PW+1)'(cw)) - $signed((PW+1)'(fw));
    pb = (PW+1)'(top) + $signed((PW+1)'(ch)) - $signed((PW+1)'(fh));
    mx = fw - cw;
    my = fh - ch;
    if (left < 0) left_c = '0;
    else if (left > $signed(PW'(mx))) left_c = $signed(PW'(mx));
    else left_c = left;
    if (top < 0) top_c = '0;
    else if (top > $signed(PW'(my))) top_c = $signed(PW'(my));
    else top_c = top;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      smooth_x    <= sx;
      smooth_y    <= sy;
      crop_width  <= cw;
      crop_height <= ch;
      if (cfg.replicate_border) begin
        crop_left  <= left;
        crop_top   <= top;
        pad_left   <= (left < 0) ? PW'(-left) : '0;
        pad_top    <= (top < 0) ? PW'(-top) : '0;
        pad_right  <= (pr < 0) ? '0 : PW'(pr);
        pad_bottom <= (pb < 0) ? '0 : PW'(pb);
      end else begin
        crop_left  <= left_c;
        crop_top   <= top_c;
        pad_left   <= '0;
        pad_top    <= '0;
        pad_right  <= '0;
        pad_bottom <= '0;
      end
    end
  end

endmodule

[rtl/rcwt_ctrl.sv]
// controller state machine sequencing history update, divisions and products
// uses rcwt_pkg; drives the datapath through cmd_t, reads stat_t
module rcwt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  rcwt_pkg::stat_t stat,
  output rcwt_pkg::cmd_t  cmd
);

  rcwt_pkg::state_t   state, state_next;
  rcwt_pkg::div_sel_t div_sel, div_sel_next;
  rcwt_pkg::mul_sel_t mul_sel, mul_sel_next;
  logic               out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rcwt_pkg::S_IDLE;
      div_sel   <= rcwt_pkg::D_MEAN_X;
      mul_sel   <= rcwt_pkg::M_A;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      div_sel <= div_sel_next;
      mul_sel <= mul_sel_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next   = state;
    div_sel_next = div_sel;
    mul_sel_next = mul_sel;
    unique case (state)
      rcwt_pkg::S_IDLE:   if (in_valid) state_next = rcwt_pkg::S_CENTER;
      rcwt_pkg::S_CENTER: state_next = rcwt_pkg::S_CHK;
      rcwt_pkg::S_CHK:    state_next = stat.full ? rcwt_pkg::S_RD_F : rcwt_pkg::S_WRITE;
      rcwt_pkg::S_RD_F:   state_next = rcwt_pkg::S_SUB_F;
      rcwt_pkg::S_SUB_F:  state_next = rcwt_pkg::S_WRITE;
      rcwt_pkg::S_WRITE:  state_next = rcwt_pkg::S_TRIM;
      rcwt_pkg::S_TRIM: begin
        if (stat.over) begin
          state_next = rcwt_pkg::S_RD_T;
        end else begin
          state_next   = rcwt_pkg::S_DIV_GO;
          div_sel_next = rcwt_pkg::D_MEAN_X;
        end
      end
      rcwt_pkg::S_RD_T:   state_next = rcwt_pkg::S_SUB_T;
      rcwt_pkg::S_SUB_T:  state_next = rcwt_pkg::S_TRIM;
      rcwt_pkg::S_DIV_GO: state_next = rcwt_pkg::S_DIV_WAIT;
      rcwt_pkg::S_DIV_WAIT: begin
        if (stat.div_done) begin
          unique case (div_sel)
            rcwt_pkg::D_MEAN_X: begin
              state_next   = rcwt_pkg::S_DIV_GO;
              div_sel_next = rcwt_pkg::D_MEAN_Y;
            end
            rcwt_pkg::D_MEAN_Y: begin
              state_next   = rcwt_pkg::S_MUL;
              mul_sel_next = rcwt_pkg::M_A;
            end
            rcwt_pkg::D_SIZE1: begin
              state_next   = rcwt_pkg::S_DIV_GO;
              div_sel_next = rcwt_pkg::D_SIZE2;
            end
            default: state_next = rcwt_pkg::S_FIN;
          endcase
        end
      end
      rcwt_pkg::S_MUL: begin
        unique case (mul_sel)
          rcwt_pkg::M_A:  mul_sel_next = rcwt_pkg::M_B;
          rcwt_pkg::M_B:  mul_sel_next = rcwt_pkg::M_BZ;
          rcwt_pkg::M_BZ: state_next   = rcwt_pkg::S_CMP;
          default: begin
            state_next   = rcwt_pkg::S_DIV_GO;
            div_sel_next = rcwt_pkg::D_SIZE1;
          end
        endcase
      end
      rcwt_pkg::S_CMP: begin
        state_next   = rcwt_pkg::S_MUL;
        mul_sel_next = rcwt_pkg::M_Z;
      end
      rcwt_pkg::S_FIN:    if (out_free) state_next = rcwt_pkg::S_IDLE;
      default:            state_next = rcwt_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd         = '0;
    cmd.div_sel = div_sel;
    cmd.mul_sel = mul_sel;
    in_stall    = (state != rcwt_pkg::S_IDLE);
    unique case (state)
      rcwt_pkg::S_IDLE:     cmd.capture   = in_valid;
      rcwt_pkg::S_CENTER:   cmd.center    = 1'b1;
      rcwt_pkg::S_RD_F,
      rcwt_pkg::S_RD_T:     cmd.rd        = 1'b1;
      rcwt_pkg::S_SUB_F,
      rcwt_pkg::S_SUB_T:    cmd.sub       = 1'b1;
      rcwt_pkg::S_WRITE:    cmd.write     = 1'b1;
      rcwt_pkg::S_DIV_GO:   cmd.div_start = 1'b1;
      rcwt_pkg::S_DIV_WAIT: cmd.div_store = stat.div_done;
      rcwt_pkg::S_MUL:      cmd.mul_go    = 1'b1;
      rcwt_pkg::S_CMP:      cmd.cmp       = 1'b1;
      rcwt_pkg::S_FIN:      cmd.out_load  = out_free;
      default:              cmd.capture   = 1'b0;
    endcase
  end

endmodule

[rtl/roi_crop_window_tracker_top.sv]
// top level of the roi crop window tracker
// holds the configuration registers; uses rcwt_pkg, rcwt_ctrl, rcwt_datapath
//
// usage
// - one request per video frame on the input channel (in_valid / in_stall):
//   clip_start, roi_valid and the q13.4 center roi_x / roi_y
// - one result per request on the output channel (out_valid / out_stall):
//   smoothed center, crop origin and size, and border pads
// - configuration through cfg_we / cfg_index / cfg_data, one register per
//   write; the user writes only while no request is in flight, which the
//   block itself does not enforce
// timing
// - a request takes four passes of the shared 36-step radix-2 divider (two
//   means, two crop sizes) and four passes through the multiplier, plus a
//   read and a subtract step for the oldest entry once the history is full
//   and for each entry dropped when the window shrinks
// - in_stall stays high while a request is being worked on
// - the result sits in an output register; the next request is taken while
//   it waits, and its result waits in the last step until the register frees
// reset
// - rst clears the history, the last center and the controller; config
//   registers return to 1280x720, zoom 1.0, window 1, replicate mode
module roi_crop_window_tracker_top #(
  parameter int MAX_WINDOW = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               clip_start,
  input  logic               roi_valid,
  input  logic signed [16:0] roi_x,
  input  logic signed [16:0] roi_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] smooth_x,
  output logic signed [16:0] smooth_y,
  output logic signed [13:0] crop_left,
  output logic signed [13:0] crop_top,
  output logic [12:0]        crop_width,
  output logic [12:0]        crop_height,
  output logic [13:0]        pad_left,
  output logic [13:0]        pad_top,
  output logic [13:0]        pad_right,
  output logic [13:0]        pad_bottom,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  rcwt_pkg::cfg_t  cfg;
  rcwt_pkg::cmd_t  cmd;
  rcwt_pkg::stat_t stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width      <= 13'd1280;
      cfg.frame_height     <= 13'd720;
      cfg.out_width        <= 13'd0;
      cfg.out_height       <= 13'd0;
      cfg.zoom_q8          <= 16'd256;
      cfg.smoothing_window <= 6'd1;
      cfg.replicate_border <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rcwt_pkg::REG_FRAME_WIDTH:  cfg.frame_width      <= cfg_data[12:0];
        rcwt_pkg::REG_FRAME_HEIGHT: cfg.frame_height     <= cfg_data[12:0];
        rcwt_pkg::REG_OUT_WIDTH:    cfg.out_width        <= cfg_data[12:0];
        rcwt_pkg::REG_OUT_HEIGHT:   cfg.out_height       <= cfg_data[12:0];
        rcwt_pkg::REG_ZOOM:         cfg.zoom_q8          <= cfg_data;
        rcwt_pkg::REG_WINDOW:       cfg.smoothing_window <= cfg_data[5:0];
        rcwt_pkg::REG_REPLICATE:    cfg.replicate_border <= cfg_data[0];
        default:                    cfg.replicate_border <= cfg.replicate_border;
      endcase
    end
  end

  // sequencer
  rcwt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // history, arithmetic and output register
  rcwt_datapath #(.MAX_WINDOW(MAX_WINDOW)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .stat        (stat),
    .clip_start  (clip_start),
    .roi_valid   (roi_valid),
    .roi_x       (roi_x),
    .roi_y       (roi_y),
    .smooth_x    (smooth_x),
    .smooth_y    (smooth_y),
    .crop_left   (crop_left),
    .crop_top    (crop_top),
    .crop_width  (crop_width),
    .crop_height (crop_height),
    .pad_left    (pad_left),
    .pad_top     (pad_top),
    .pad_right   (pad_right),
    .pad_bottom  (pad_bottom)
  );

  // an accepted request keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while block not busy after acceptance");

  // a result appears only at the end of a request's work
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a request in flight");

  // crop size always within one pixel and the largest frame
  a_crop_size: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (crop_width != 13'd0 && crop_width <= 13'd4096 &&
                   crop_height != 13'd0 && crop_height <= 13'd4096))
    else $error("crop size out of range");

endmodule

[dv/roi_crop_window_tracker_top_test.sv]
// self-checking testbench for the roi crop window tracker top level
// drives frame requests and register settings, predicts each result; needs rcwt_pkg and the rtl
`timescale 1ns / 100ps

module roi_crop_window_tracker_top_test;

  localparam int HIST_DEPTH = 32;
  localparam int REQ_SLOTS = 4096;      // room for every request of the run
  localparam int DRAIN_WAIT = 300;      // latency plus worst window shrink, with margin
  localparam int STALL_LIMIT = 20000;   // cycles with no request moving on either side

  typedef struct {
    logic              clip;
    logic              roi_ok;
    logic signed [16:0] x;
    logic signed [16:0] y;
  } frame_req_t;

  typedef struct {
    logic signed [16:0] sx;
    logic signed [16:0] sy;
    logic signed [13:0] left;
    logic signed [13:0] top;
    logic [12:0]        cw;
    logic [12:0]        ch;
    logic [13:0]        pl;
    logic [13:0]        pt;
    logic [13:0]        pr;
    logic [13:0]        pb;
  } crop_res_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_stall, clip_start, roi_valid;
  logic signed [16:0] roi_x, roi_y;
  logic out_valid, out_stall;
  logic signed [16:0] smooth_x, smooth_y;
  logic signed [13:0] crop_left, crop_top;
  logic [12:0] crop_width, crop_height;
  logic [13:0] pad_left, pad_top, pad_right, pad_bottom;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  roi_crop_window_tracker_top i_dut (.*);

  always #10 clk = ~clk;

  // requests waiting to be driven and results waiting to be seen
  frame_req_t pending_reqs[REQ_SLOTS];
  int req_wr = 0;
  int req_rd = 0;
  crop_res_t  expected_crops[REQ_SLOTS];
  int exp_wr = 0;
  int exp_rd = 0;

  int errors = 0;
  int reqs_taken = 0;
  int crops_seen = 0;
  int clamp_phases = 0;
  int hold_left = 0;
  bit hold_done = 0;

  // shadow registers
  longint unsigned sh_fw, sh_fh, sh_ow, sh_oh, sh_zoom, sh_win, sh_rep;

  // shadow tracking state
  longint tr_hx[HIST_DEPTH];
  longint tr_hy[HIST_DEPTH];
  longint unsigned tr_count, tr_head;
  longint tr_sum_x, tr_sum_y, tr_last_x, tr_last_y;
  bit tr_have_last;

  // no idling while this many requests have been taken
  function automatic bit calm();
    return reqs_taken >= 700 && reqs_taken < 1000;
  endfunction

  function automatic longint unsigned div_near(longint unsigned n, longint unsigned d);
    return (2 * n + d) / (2 * d);
  endfunction

  // ties away from zero
  function automatic longint div_near_s(longint n, longint unsigned d);
    if (n >= 0) return longint'(div_near(n, d));
    return -longint'(div_near(-n, d));
  endfunction

  // half-pixel q13.4 units to whole pixels
  function automatic longint to_pixels(longint v);
    if (v >= 0) return (v + (1 << rcwt_pkg::COORD_FRAC)) >>> (rcwt_pkg::COORD_FRAC + 1);
    return -((-v + (1 << rcwt_pkg::COORD_FRAC)) >>> (rcwt_pkg::COORD_FRAC + 1));
  endfunction

  function automatic longint unsigned size_sat(longint unsigned v, longint unsigned lo);
    if (v < lo) return lo;
    if (v > 4096) return 4096;
    return v;
  endfunction

  function automatic void clear_track();
    for (int i = 0; i < HIST_DEPTH; i++) begin
      tr_hx[i] = 0;
      tr_hy[i] = 0;
    end
    tr_count = 0;
    tr_head = 0;
    tr_sum_x = 0;
    tr_sum_y = 0;
    tr_last_x = 0;
    tr_last_y = 0;
    tr_have_last = 0;
  endfunction

  function automatic void drop_oldest();
    longint unsigned idx;
    idx = (tr_head + HIST_DEPTH - tr_count) % HIST_DEPTH;
    tr_sum_x -= tr_hx[idx];
    tr_sum_y -= tr_hy[idx];
    tr_count--;
  endfunction

  // smooth the center and place the crop for one frame request
  function automatic crop_res_t track_frame(frame_req_t r);
    longint unsigned fw, fh, ow, oh, z, win, cw, ch;
    longint cx, cy, sx, sy, left, top, mx, my;
    longint pl, pt, pr, pb;
    crop_res_t res;
    fw = size_sat(sh_fw, 1);
    fh = size_sat(sh_fh, 1);
    ow = size_sat(sh_ow, 0);
    oh = size_sat(sh_oh, 0);
    z = sh_zoom < 256 ? 256 : sh_zoom;
    win = sh_win == 0 ? 1 : sh_win;
    if (win > HIST_DEPTH) win = HIST_DEPTH;
    if (ow == 0 || oh == 0) begin
      ow = fw;
      oh = fh;
    end
    if (r.clip) clear_track();
    if (r.roi_ok) begin
      cx = r.x;
      cy = r.y;
    end else if (tr_have_last) begin
      cx = tr_last_x;
      cy = tr_last_y;
    end else begin
      cx = div_near(fw << rcwt_pkg::COORD_FRAC, 2);
      cy = div_near(fh << rcwt_pkg::COORD_FRAC, 2);
    end
    if (tr_count >= HIST_DEPTH) drop_oldest();
    tr_hx[tr_head] = cx;
    tr_hy[tr_head] = cy;
    tr_sum_x += cx;
    tr_sum_y += cy;
    tr_head = (tr_head + 1) % HIST_DEPTH;
    tr_count++;
    while (tr_count > win) drop_oldest();
    sx = div_near_s(tr_sum_x, tr_count);
    sy = div_near_s(tr_sum_y, tr_count);
    tr_last_x = sx;
    tr_last_y = sy;
    tr_have_last = 1;
    // fit by width unless that makes the crop too tall
    if (fw * 256 * oh > fh * z * ow) begin
      ch = div_near(fh * 256, z);
      cw = div_near(fh * 256 * ow, z * oh);
    end else begin
      cw = div_near(fw * 256, z);
      ch = div_near(fw * 256 * oh, z * ow);
    end
    cw = cw < 1 ? 1 : (cw > fw ? fw : cw);
    ch = ch < 1 ? 1 : (ch > fh ? fh : ch);
    left = to_pixels(2 * sx - longint'(cw << rcwt_pkg::COORD_FRAC));
    top = to_pixels(2 * sy - longint'(ch << rcwt_pkg::COORD_FRAC));
    pl = 0;
    pt = 0;
    pr = 0;
    pb = 0;
    if (sh_rep != 0) begin
      pl = left < 0 ? -left : 0;
      pt = top < 0 ? -top : 0;
      pr = left + longint'(cw) - longint'(fw);
      if (pr < 0) pr = 0;
      pb = top + longint'(ch) - longint'(fh);
      if (pb < 0) pb = 0;
    end else begin
      mx = longint'(fw) - longint'(cw);
      my = longint'(fh) - longint'(ch);
      if (left < 0) left = 0;
      if (left > mx) left = mx;
      if (top < 0) top = 0;
      if (top > my) top = my;
    end
    res.sx = sx[16:0];
    res.sy = sy[16:0];
    res.left = left[13:0];
    res.top = top[13:0];
    res.cw = cw[12:0];
    res.ch = ch[12:0];
    res.pl = pl[13:0];
    res.pt = pt[13:0];
    res.pr = pr[13:0];
    res.pb = pb[13:0];
    return res;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("crop %0d: %s got %0d want %0d", crops_seen, what, got, want);
    errors++;
  endtask

  // request driver: reloads only when the current request is taken or none is up
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        expected_crops[exp_wr] = track_frame(frame_req_t'{clip_start, roi_valid,
                                                          roi_x, roi_y});
        exp_wr++;
        reqs_taken++;
      end
      if (req_rd == req_wr || (!calm() && $urandom_range(99) < 12)) begin
        in_valid <= 1'b0;
      end else begin
        frame_req_t r;
        r = pending_reqs[req_rd];
        req_rd++;
        in_valid <= 1'b1;
        clip_start <= r.clip;
        roi_valid <= r.roi_ok;
        roi_x <= r.x;
        roi_y <= r.y;
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (exp_rd == exp_wr) begin
          report("unexpected result, count", 1, 0);
        end else begin
          crop_res_t e;
          e = expected_crops[exp_rd];
          exp_rd++;
          if (smooth_x !== e.sx) report("smooth_x", smooth_x, e.sx);
          if (smooth_y !== e.sy) report("smooth_y", smooth_y, e.sy);
          if (crop_left !== e.left) report("crop_left", crop_left, e.left);
          if (crop_top !== e.top) report("crop_top", crop_top, e.top);
          if (crop_width !== e.cw) report("crop_width", crop_width, e.cw);
          if (crop_height !== e.ch) report("crop_height", crop_height, e.ch);
          if (pad_left !== e.pl) report("pad_left", pad_left, e.pl);
          if (pad_top !== e.pt) report("pad_top", pad_top, e.pt);
          if (pad_right !== e.pr) report("pad_right", pad_right, e.pr);
          if (pad_bottom !== e.pb) report("pad_bottom", pad_bottom, e.pb);
        end
        crops_seen++;
      end
      // one long hold-off so the block backs up and stalls its input
      if (!hold_done && reqs_taken >= 1200) begin
        hold_done <= 1'b1;
        hold_left <= 3000;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm() && $urandom_range(99) < 12;
      end
    end
  end

  // watchdog on cycles in which nothing moves
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [2:0] idx, longint unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    case (idx)
      rcwt_pkg::REG_FRAME_WIDTH:  sh_fw = val & 16'h1fff;
      rcwt_pkg::REG_FRAME_HEIGHT: sh_fh = val & 16'h1fff;
      rcwt_pkg::REG_OUT_WIDTH:    sh_ow = val & 16'h1fff;
      rcwt_pkg::REG_OUT_HEIGHT:   sh_oh = val & 16'h1fff;
      rcwt_pkg::REG_ZOOM:         sh_zoom = val & 16'hffff;
      rcwt_pkg::REG_WINDOW:       sh_win = val & 16'h3f;
      rcwt_pkg::REG_REPLICATE:    sh_rep = val & 16'h1;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(longint unsigned fw, longint unsigned fh, longint unsigned ow,
                         longint unsigned oh, longint unsigned z, longint unsigned win,
                         longint unsigned rep);
    write_reg(rcwt_pkg::REG_FRAME_WIDTH, fw);
    write_reg(rcwt_pkg::REG_FRAME_HEIGHT, fh);
    write_reg(rcwt_pkg::REG_OUT_WIDTH, ow);
    write_reg(rcwt_pkg::REG_OUT_HEIGHT, oh);
    write_reg(rcwt_pkg::REG_ZOOM, z);
    write_reg(rcwt_pkg::REG_WINDOW, win);
    write_reg(rcwt_pkg::REG_REPLICATE, rep);
    if (rep == 0) clamp_phases++;
  endtask

  task automatic add_req(bit clip, bit ok, longint x, longint y);
    pending_reqs[req_wr] = frame_req_t'{clip, ok, x[16:0], y[16:0]};
    req_wr++;
  endtask

  // mostly tracked centers near a drifting point, some noise and gaps
  task automatic add_random(int n);
    longint px, py;
    px = $urandom_range(65535);
    py = $urandom_range(65535);
    for (int i = 0; i < n; i++) begin
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) begin
        px = px + $signed($urandom_range(512)) - 256;
        py = py + $signed($urandom_range(512)) - 256;
        add_req(pick < 3, 1'b1, px, py);
      end else if (pick < 85) begin
        add_req($urandom_range(19) == 0, 1'b1,
                $signed(17'($urandom())), $signed(17'($urandom())));
      end else begin
        add_req($urandom_range(9) == 0, 1'b0,
                $signed(17'($urandom())), $signed(17'($urandom())));
      end
    end
  endtask

  task automatic drain();
    while (req_rd != req_wr || in_valid || exp_rd != exp_wr)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    clip_start <= 1'b0;
    roi_valid <= 1'b0;
    roi_x <= '0;
    roi_y <= '0;
    out_stall <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= rcwt_pkg::REG_FRAME_WIDTH;
    cfg_data <= '0;
    // reset defaults
    sh_fw = 1280;
    sh_fh = 720;
    sh_ow = 0;
    sh_oh = 0;
    sh_zoom = 256;
    sh_win = 1;
    sh_rep = 1;
    clear_track();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: frame middle before any center, extremes, held center
    add_req(1'b0, 1'b0, 0, 0);
    add_req(1'b0, 1'b0, 0, 0);
    add_req(1'b0, 1'b1, 65535, 65535);
    add_req(1'b0, 1'b1, -65536, -65536);
    add_req(1'b0, 1'b0, 1, 1);
    add_req(1'b1, 1'b0, 0, 0);
    add_req(1'b0, 1'b1, 0, 0);
    add_req(1'b1, 1'b1, -1, 1);
    add_req(1'b0, 1'b1, 65535, -65536);
    add_random(180);
    drain();

    for (int ph = 1; ph < 10; ph++) begin
      case (ph)
        // tiny frame, extreme aspect, zoom below one, widest window, clamp
        1: set_all(1, 1, 4096, 1, 0, 32, 0);
        // biggest frame, zero output width, max zoom, zero window
        2: set_all(4096, 4096, 0, 5, 65535, 0, 1);
        // out of range sizes and window, then a shrink of the window to one
        3: set_all(8191, 0, 8191, 4096, 300, 63, 0);
        4: set_all(4096, 2160, 1, 4096, 256, 1, 1);
        default: begin
          set_all($urandom_range(1, 4096), $urandom_range(1, 4096),
                  $urandom_range(9) == 0 ? 0 : $urandom_range(1, 4096),
                  $urandom_range(9) == 0 ? 0 : $urandom_range(1, 4096),
                  $urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(1024),
                  $urandom_range(34), $urandom_range(1));
        end
      endcase
      // a few requests right after the switch, then the random body
      add_req(1'b0, 1'b0, 0, 0);
      add_req(1'b0, 1'b1, -65536, 65535);
      add_random(190);
      drain();
    end

    $display("%0d frame requests over 10 register settings (%0d clamp mode),", reqs_taken,
             clamp_phases);
    $display("%0d crop results checked, %0d field mismatches", crops_seen, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
